// File: rtl/core/matrix_chain_order_cost_defines.svh
// Assertion macros for the matrix chain order cost block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MATRIX_CHAIN_ORDER_COST_DEFINES_SVH
`define MATRIX_CHAIN_ORDER_COST_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MCOC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcoc check failed: same-cycle rule");

// Next-cycle implication, disabled during reset
`define MCOC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcoc check failed: next-cycle rule");

`endif

// File: rtl/core/mcoc_pkg.sv
// Shared constants, types and a helper function for the matrix chain order cost block.
// No dependencies.
`timescale 1ns / 1ps

package mcoc_pkg;

    // Sizing
    localparam int MAX_DIMS = 32;
    localparam int IDX_W    = $clog2(MAX_DIMS);
    localparam int CNT_W    = $clog2(MAX_DIMS + 1);
    localparam int CADDR_W  = 2 * IDX_W;
    localparam int DIM_W    = 16;
    localparam int MUL1_W   = 2 * DIM_W;
    localparam int PROD_W   = 3 * DIM_W;
    localparam int COST_W   = 53;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENTRY,
        ST_SPLIT,
        ST_DRAIN
    } mcoc_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             dim_we;
        logic [IDX_W-1:0] dim_wr_idx;
        logic [IDX_W-1:0] dim_rd_a;
        logic [IDX_W-1:0] dim_rd_b;
        logic             issue;
        logic             first;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] split;
        logic             cost_we;
        logic             emit;
        logic             emit_err;
        logic             emit_cost;
    } mcoc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_busy;
    } mcoc_status_t;

    // Saturating add; both operands are at most COST_MAX
    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

endpackage

// File: rtl/core/mcoc_datapath.sv
// Datapath: dimension store, cost table, split-evaluation pipeline and result registers.
// Depends on mcoc_pkg; driven by mcoc_ctrl commands.
`timescale 1ns / 1ps

module mcoc_datapath
    import mcoc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mcoc_cmd_t         cmd,
    input  logic [DIM_W-1:0]  dim_value,
    output mcoc_status_t      status,
    output logic              done,
    output logic [COST_W-1:0] min_cost,
    output logic              chain_error
);

    // Memories
    logic [DIM_W-1:0]  dim_mem  [MAX_DIMS];
    logic [COST_W-1:0] cost_mem [2**CADDR_W];

    logic [DIM_W-1:0]  dim_q_a_reg;
    logic [DIM_W-1:0]  dim_q_b_reg;
    logic [COST_W-1:0] cost_q_a_reg;
    logic [COST_W-1:0] cost_q_b_reg;

    // Pipeline
    logic              v1_reg, v2_reg, v3_reg;
    logic              fst1_reg, fst2_reg, fst3_reg;
    logic              zl1_reg, zr1_reg;
    logic [DIM_W-1:0]  drow_reg;
    logic [MUL1_W-1:0] m1_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [COST_W-1:0] sum_reg, sum2_reg;
    logic [COST_W-1:0] best_reg;

    // Results
    logic              done_reg;
    logic [COST_W-1:0] min_cost_reg;
    logic              chain_error_reg;

    logic [IDX_W-1:0]  split_inc;
    logic [CADDR_W-1:0] cost_addr_a, cost_addr_b, cost_addr_w;
    logic [COST_W-1:0] cand;

    assign split_inc   = cmd.split + IDX_W'(1);
    assign cost_addr_a = {cmd.row, cmd.split};
    assign cost_addr_b = {split_inc, cmd.col};
    assign cost_addr_w = {cmd.row, cmd.col};

    // Candidate cost of the split leaving the pipeline
    assign cand = sat_add(sum2_reg, COST_W'(prod_reg));

    // Dimension store: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.dim_we)
        begin
            dim_mem[cmd.dim_wr_idx] <= dim_value;
        end
        dim_q_a_reg <= dim_mem[cmd.dim_rd_a];
        dim_q_b_reg <= dim_mem[cmd.dim_rd_b];
    end

    // Cost table: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.cost_we)
        begin
            cost_mem[cost_addr_w] <= best_reg;
        end
        cost_q_a_reg <= cost_mem[cost_addr_a];
        cost_q_b_reg <= cost_mem[cost_addr_b];
    end

    // Pipeline control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= cmd.issue;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= cmd.emit;
        end
    end

    // Pipeline payload; diagonal entries read as zero
    always_ff @(posedge clk)
    begin
        fst1_reg <= cmd.first;
        zl1_reg  <= (cmd.split == cmd.row);
        zr1_reg  <= (split_inc == cmd.col);
        if (cmd.issue && cmd.first)
        begin
            drow_reg <= dim_q_a_reg;
        end

        fst2_reg <= fst1_reg;
        m1_reg   <= MUL1_W'(drow_reg) * MUL1_W'(dim_q_a_reg);
        sum_reg  <= sat_add(zl1_reg ? '0 : cost_q_a_reg, zr1_reg ? '0 : cost_q_b_reg);

        fst3_reg <= fst2_reg;
        prod_reg <= PROD_W'(m1_reg) * PROD_W'(dim_q_b_reg);
        sum2_reg <= sum_reg;

        if (v3_reg && (fst3_reg || (cand < best_reg)))
        begin
            best_reg <= cand;
        end

        if (cmd.emit)
        begin
            min_cost_reg    <= cmd.emit_cost ? best_reg : '0;
            chain_error_reg <= cmd.emit_err;
        end
    end

    assign status.pipe_busy = v1_reg | v2_reg | v3_reg;
    assign done             = done_reg;
    assign min_cost         = min_cost_reg;
    assign chain_error      = chain_error_reg;

endmodule

// File: rtl/core/mcoc_ctrl.sv
// Controller: chain loading, diagonal/row/split sequencing and result issue.
// Depends on mcoc_pkg; commands mcoc_datapath.
`timescale 1ns / 1ps

module mcoc_ctrl
    import mcoc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         last_dim,
    input  mcoc_status_t status,
    output logic         busy,
    output mcoc_cmd_t    cmd
);

    mcoc_state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] mats_reg, mats_next;
    logic [IDX_W-1:0] span_reg, span_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] split_reg, split_next;

    logic [IDX_W-1:0] col;
    logic [IDX_W:0]   col_inc, split_inc, span_inc;
    logic             full;
    logic [CNT_W-1:0] new_count;
    logic             new_ovf;

    assign col       = row_reg + span_reg;
    assign col_inc   = (IDX_W+1)'(col) + (IDX_W+1)'(1);
    assign split_inc = (IDX_W+1)'(split_reg) + (IDX_W+1)'(1);
    assign span_inc  = (IDX_W+1)'(span_reg) + (IDX_W+1)'(1);
    assign full      = (count_reg == CNT_W'(MAX_DIMS));
    assign new_count = full ? count_reg : count_reg + CNT_W'(1);
    assign new_ovf   = ovf_reg | full;
    assign busy      = (state_reg != ST_IDLE);

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            mats_reg  <= '0;
            span_reg  <= '0;
            row_reg   <= '0;
            split_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            mats_reg  <= mats_next;
            span_reg  <= span_next;
            row_reg   <= row_next;
            split_reg <= split_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        mats_next  = mats_reg;
        span_next  = span_reg;
        row_next   = row_reg;
        split_next = split_reg;

        cmd            = '0;
        cmd.dim_wr_idx = count_reg[IDX_W-1:0];
        cmd.dim_rd_a   = row_reg;
        cmd.dim_rd_b   = col_inc[IDX_W-1:0];
        cmd.row        = row_reg;
        cmd.col        = col;
        cmd.split      = split_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.dim_we = !full;
                    if (!last_dim)
                    begin
                        count_next = new_count;
                        ovf_next   = new_ovf;
                    end
                    else
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        if (new_ovf || (new_count < CNT_W'(2)))
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_err = 1'b1;
                        end
                        else if (new_count == CNT_W'(2))
                        begin
                            cmd.emit = 1'b1;
                        end
                        else
                        begin
                            mats_next  = IDX_W'(new_count - CNT_W'(1));
                            span_next  = IDX_W'(1);
                            row_next   = '0;
                            state_next = ST_ENTRY;
                        end
                    end
                end
            end

            // Fetch the row dimension; col+1 is read on port B throughout
            ST_ENTRY:
            begin
                split_next = row_reg;
                state_next = ST_SPLIT;
            end

            // One split point per cycle
            ST_SPLIT:
            begin
                cmd.issue    = 1'b1;
                cmd.first    = (split_reg == row_reg);
                cmd.dim_rd_a = split_inc[IDX_W-1:0];
                if (split_inc == (IDX_W+1)'(col))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    split_next = split_inc[IDX_W-1:0];
                end
            end

            // Wait for the pipeline, then store the entry and move on
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    cmd.cost_we = 1'b1;
                    if (col_inc < (IDX_W+1)'(mats_reg))
                    begin
                        row_next   = row_reg + IDX_W'(1);
                        state_next = ST_ENTRY;
                    end
                    else if (span_inc < (IDX_W+1)'(mats_reg))
                    begin
                        span_next  = span_inc[IDX_W-1:0];
                        row_next   = '0;
                        state_next = ST_ENTRY;
                    end
                    else
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_cost = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/matrix_chain_order_cost.sv
// Matrix chain order cost: minimum scalar multiplication count of a matrix chain.
// Depends on mcoc_pkg, mcoc_ctrl, mcoc_datapath and matrix_chain_order_cost_defines.svh.
//
// Usage:
//   Input: one dimension per transaction on dim_value, taken at a clock edge with
//   start high and busy low. last_dim closes the chain. A chain of k matrices
//   sends k+1 dimensions; up to MAX_DIMS (32) are stored.
//   Output: one transaction per chain, on min_cost / chain_error, marked by done for
//   exactly one cycle. chain_error is set (min_cost 0) when fewer than two or
//   more than MAX_DIMS dimensions arrived. The receiver cannot stall; the result
//   is valid only in the done cycle.
//   Timing: busy stays low while dimensions without last_dim are taken. A closing
//   dimension with an error or a single matrix gives done in the next cycle. Otherwise,
//   with m matrices, busy stays high while the cost table is filled: one table entry
//   at a time, (m-span) entries for each span=1..m-1. The bound is the single split
//   pipeline, which evaluates one split point per cycle against the two-read-port
//   cost table.
//   Reset: clears the dimension count and the controller; the stores need no clearing.
`timescale 1ns / 1ps
`include "matrix_chain_order_cost_defines.svh"

module matrix_chain_order_cost
    import mcoc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [DIM_W-1:0]  dim_value,
    input  logic              last_dim,
    output logic              done,
    output logic [COST_W-1:0] min_cost,
    output logic              chain_error
);

    mcoc_cmd_t    cmd;
    mcoc_status_t status;

    // Sequencer
    mcoc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last_dim (last_dim),
        .status   (status),
        .busy     (busy),
        .cmd      (cmd)
    );

    // Stores and arithmetic
    mcoc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .dim_value   (dim_value),
        .status      (status),
        .done        (done),
        .min_cost    (min_cost),
        .chain_error (chain_error)
    );

    // Checks
    `MCOC_ASSERT_NOW(a_err_cost_zero, done && chain_error, min_cost == '0)
    `MCOC_ASSERT_NOW(a_done_idle, done, !busy)
    `MCOC_ASSERT_NEXT(a_mid_no_result, start && !busy && !last_dim, !done)

endmodule
